### rtl/tse_pkg.sv
// Shared types, phase codes and field helpers for the time set editor.
`default_nettype none

package tse_pkg;

    // Edit phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_FETCH  = 3'd1;
    localparam logic [2:0] PH_HOUR   = 3'd2;
    localparam logic [2:0] PH_MINUTE = 3'd3;
    localparam logic [2:0] PH_SECOND = 3'd4;
    localparam logic [2:0] PH_WRITE  = 3'd5;

    // Blanked field codes
    localparam logic [1:0] BLANK_NONE   = 2'd0;
    localparam logic [1:0] BLANK_HOUR   = 2'd1;
    localparam logic [1:0] BLANK_MINUTE = 2'd2;
    localparam logic [1:0] BLANK_SECOND = 2'd3;

    // Top value of each field (modulus minus one)
    localparam logic [5:0] HOUR_TOP = 6'd23;
    localparam logic [5:0] MIN_TOP  = 6'd59;

    // Auto-repeat starts above this hold count
    localparam logic [7:0] REPEAT_START = 8'd20;

    // Decoded key state for one tick
    typedef struct packed {
        logic up;
        logic down;
        logic mpress;
        logic quiet;
    } key_t;

    // One result item
    typedef struct packed {
        logic [2:0] phase;
        logic [4:0] shown_hour;
        logic [5:0] shown_minute;
        logic [5:0] shown_second;
        logic [1:0] blank_field;
        logic       rtc_write;
        logic [4:0] stored_hour;
        logic [5:0] stored_minute;
        logic [5:0] stored_second;
    } result_t;

    // True when n is a multiple of 5; 16 = 1 mod 5, so fold nibbles twice
    function automatic logic div5(input logic [7:0] n);
        logic [4:0] s;
        logic [4:0] t;
        begin
            s = {1'b0, n[7:4]} + {1'b0, n[3:0]};
            t = {4'd0, s[4]} + {1'b0, s[3:0]};
            div5 = (t == 5'd0) || (t == 5'd5) || (t == 5'd10) || (t == 5'd15);
        end
    endfunction

    // Press on the first tick of a hold, then auto-repeat every fifth tick
    function automatic logic step_pressed(input logic [7:0] n);
        begin
            step_pressed = (n == 8'd1) || ((n > REPEAT_START) && div5(n));
        end
    endfunction

    // Increase, then decrease, with wrap over 0..top in both directions
    function automatic logic [5:0] bump_field(input logic [5:0] v, input logic [5:0] top,
                                              input logic up, input logic down);
        logic [5:0] w;
        begin
            w = v;
            if (up)
            begin
                w = (w >= top) ? (w - top) : (w + 6'd1);
            end
            if (down)
            begin
                w = ((w == 6'd0) || (w > (top + 6'd1))) ? top : (w - 6'd1);
            end
            bump_field = w;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/tse_key_decode.sv
// Key hold count decoder: press, auto-repeat and quiet detection.
`default_nettype none

module tse_key_decode (
    input  wire logic [7:0]    inc_hold,
    input  wire logic [7:0]    dec_hold,
    input  wire logic [7:0]    mode_hold,
    output tse_pkg::key_t      keys
);

    // Step keys repeat, mode key only on first tick
    always_comb
    begin
        keys.up     = tse_pkg::step_pressed(inc_hold);
        keys.down   = tse_pkg::step_pressed(dec_hold);
        keys.mpress = (mode_hold == 8'd1);
        keys.quiet  = (inc_hold == 8'd0) && (dec_hold == 8'd0);
    end

endmodule

`default_nettype wire

### rtl/tse_edit_core.sv
// Edit state machine, working and late time registers, blink counter.
`default_nettype none

module tse_edit_core #(
    parameter int BLINK_PERIOD = 20
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             edit_target,
    input  wire tse_pkg::key_t    keys,
    input  wire logic [4:0]       rtc_hour,
    input  wire logic [5:0]       rtc_minute,
    input  wire logic [5:0]       rtc_second,
    output tse_pkg::result_t      res
);

    localparam int BW = (BLINK_PERIOD > 2) ? $clog2(BLINK_PERIOD) : 1;
    localparam logic [BW-1:0] BLINK_LAST = BW'(BLINK_PERIOD - 1);
    localparam logic [BW-1:0] BLINK_HALF = BW'(BLINK_PERIOD / 2);

    logic [2:0]    phase_reg, phase_next;
    logic [BW-1:0] blink_reg, blink_next;
    logic [4:0]    work_hour_reg, work_hour_next;
    logic [5:0]    work_minute_reg, work_minute_next;
    logic [5:0]    work_second_reg, work_second_next;
    logic [4:0]    stored_hour_reg, stored_hour_next;
    logic [5:0]    stored_minute_reg, stored_minute_next;
    logic [5:0]    stored_second_reg, stored_second_next;

    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [5:0] cur_second;
    logic [4:0] bumped_hour;
    logic [5:0] bumped_minute;
    logic [5:0] bumped_second;
    logic       blank_now;

    // Field being edited comes from the late or the working set
    assign cur_hour   = edit_target ? stored_hour_reg   : work_hour_reg;
    assign cur_minute = edit_target ? stored_minute_reg : work_minute_reg;
    assign cur_second = edit_target ? stored_second_reg : work_second_reg;

    assign bumped_hour   = 5'(tse_pkg::bump_field({1'b0, cur_hour}, tse_pkg::HOUR_TOP,
                                                  keys.up, keys.down));
    assign bumped_minute = tse_pkg::bump_field(cur_minute, tse_pkg::MIN_TOP,
                                               keys.up, keys.down);
    assign bumped_second = tse_pkg::bump_field(cur_second, tse_pkg::MIN_TOP,
                                               keys.up, keys.down);

    assign blank_now = keys.quiet && (blink_reg < BLINK_HALF);

    // Blink counter runs every tick
    assign blink_next = (blink_reg == BLINK_LAST) ? '0 : (blink_reg + 1'b1);

    // Next state and result of this tick
    always_comb
    begin
        phase_next         = tse_pkg::PH_IDLE;
        work_hour_next     = work_hour_reg;
        work_minute_next   = work_minute_reg;
        work_second_next   = work_second_reg;
        stored_hour_next   = stored_hour_reg;
        stored_minute_next = stored_minute_reg;
        stored_second_next = stored_second_reg;

        res.phase        = phase_reg;
        res.shown_hour   = cur_hour;
        res.shown_minute = cur_minute;
        res.shown_second = cur_second;
        res.blank_field  = tse_pkg::BLANK_NONE;
        res.rtc_write    = 1'b0;

        unique case (phase_reg)
            tse_pkg::PH_IDLE:
            begin
                if (!edit_target)
                begin
                    res.shown_hour   = rtc_hour;
                    res.shown_minute = rtc_minute;
                    res.shown_second = rtc_second;
                end
                if (keys.mpress)
                begin
                    phase_next = edit_target ? tse_pkg::PH_HOUR : tse_pkg::PH_FETCH;
                end
            end
            tse_pkg::PH_FETCH:
            begin
                if (!edit_target)
                begin
                    work_hour_next   = rtc_hour;
                    work_minute_next = rtc_minute;
                    work_second_next = rtc_second;
                    res.shown_hour   = rtc_hour;
                    res.shown_minute = rtc_minute;
                    res.shown_second = rtc_second;
                    phase_next       = tse_pkg::PH_HOUR;
                end
            end
            tse_pkg::PH_HOUR:
            begin
                if (blank_now)
                begin
                    res.blank_field = tse_pkg::BLANK_HOUR;
                end
                if (edit_target)
                begin
                    stored_hour_next = bumped_hour;
                end
                else
                begin
                    work_hour_next = bumped_hour;
                end
                phase_next = keys.mpress ? tse_pkg::PH_MINUTE : tse_pkg::PH_HOUR;
            end
            tse_pkg::PH_MINUTE:
            begin
                if (blank_now)
                begin
                    res.blank_field = tse_pkg::BLANK_MINUTE;
                end
                if (edit_target)
                begin
                    stored_minute_next = bumped_minute;
                end
                else
                begin
                    work_minute_next = bumped_minute;
                end
                phase_next = keys.mpress ? tse_pkg::PH_SECOND : tse_pkg::PH_MINUTE;
            end
            tse_pkg::PH_SECOND:
            begin
                if (blank_now)
                begin
                    res.blank_field = tse_pkg::BLANK_SECOND;
                end
                if (edit_target)
                begin
                    stored_second_next = bumped_second;
                end
                else
                begin
                    work_second_next = bumped_second;
                end
                if (keys.mpress)
                begin
                    phase_next = edit_target ? tse_pkg::PH_IDLE : tse_pkg::PH_WRITE;
                end
                else
                begin
                    phase_next = tse_pkg::PH_SECOND;
                end
            end
            tse_pkg::PH_WRITE:
            begin
                res.rtc_write = !edit_target;
            end
            default:
            begin
                // unused codes fall back to idle
                phase_next = tse_pkg::PH_IDLE;
            end
        endcase

        res.stored_hour   = stored_hour_next;
        res.stored_minute = stored_minute_next;
        res.stored_second = stored_second_next;
    end

    // State moves only when the item passes to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= tse_pkg::PH_IDLE;
            blink_reg         <= '0;
            work_hour_reg     <= '0;
            work_minute_reg   <= '0;
            work_second_reg   <= '0;
            stored_hour_reg   <= '0;
            stored_minute_reg <= '0;
            stored_second_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            blink_reg         <= blink_next;
            work_hour_reg     <= work_hour_next;
            work_minute_reg   <= work_minute_next;
            work_second_reg   <= work_second_next;
            stored_hour_reg   <= stored_hour_next;
            stored_minute_reg <= stored_minute_next;
            stored_second_reg <= stored_second_next;
        end
    end

endmodule

`default_nettype wire

### rtl/time_set_editor.sv
// Top level of the time set editor: input register, edit core, result register.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   input    | in_valid / in_ready       | inc_hold dec_hold mode_hold rtc_hour/min/sec
//   result   | out_valid / out_ready     | phase shown_* blank_field rtc_write late_*
//   config   | cfg_we (no wait)          | cfg_wdata -> edit_target
//
// One item per clock cycle sustained while out_ready stays high; items pass the
// input register, then the result register; edit state updates as an item enters it.
// Reset clears the phase, blink counter, working and late time, and edit_target.
// When the result register is held by out_ready low, the input register keeps
// its item and in_ready stays high only while that register is empty.
`default_nettype none

module time_set_editor #(
    parameter int BLINK_PERIOD = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  inc_hold,
    input  wire logic [7:0]  dec_hold,
    input  wire logic [7:0]  mode_hold,
    input  wire logic [4:0]  rtc_hour,
    input  wire logic [5:0]  rtc_minute,
    input  wire logic [5:0]  rtc_second,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       phase,
    output logic [4:0]       shown_hour,
    output logic [5:0]       shown_minute,
    output logic [5:0]       shown_second,
    output logic [1:0]       blank_field,
    output logic             rtc_write,
    output logic [4:0]       late_hour_out,
    output logic [5:0]       late_minute_out,
    output logic [5:0]       late_second_out,

    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata
);

    logic             edit_target_reg;
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       inc_reg, dec_reg, mode_reg;
    logic [4:0]       rtc_hour_reg;
    logic [5:0]       rtc_minute_reg, rtc_second_reg;
    logic             out_valid_reg, out_valid_next;
    tse_pkg::result_t res_reg;
    tse_pkg::result_t res_comb;
    tse_pkg::key_t    keys;
    logic             advance;
    logic             load_in;

    // Handshake control
    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign load_in        = in_valid && in_ready;
    assign in_valid_next  = load_in || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_target_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            edit_target_reg <= cfg_wdata;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input item register
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            inc_reg        <= inc_hold;
            dec_reg        <= dec_hold;
            mode_reg       <= mode_hold;
            rtc_hour_reg   <= rtc_hour;
            rtc_minute_reg <= rtc_minute;
            rtc_second_reg <= rtc_second;
        end
    end

    tse_key_decode u_keys (
        .inc_hold  (inc_reg),
        .dec_hold  (dec_reg),
        .mode_hold (mode_reg),
        .keys      (keys)
    );

    tse_edit_core #(
        .BLINK_PERIOD (BLINK_PERIOD)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .edit_target (edit_target_reg),
        .keys        (keys),
        .rtc_hour    (rtc_hour_reg),
        .rtc_minute  (rtc_minute_reg),
        .rtc_second  (rtc_second_reg),
        .res         (res_comb)
    );

    // Result item register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid       = out_valid_reg;
    assign phase           = res_reg.phase;
    assign shown_hour      = res_reg.shown_hour;
    assign shown_minute    = res_reg.shown_minute;
    assign shown_second    = res_reg.shown_second;
    assign blank_field     = res_reg.blank_field;
    assign rtc_write       = res_reg.rtc_write;
    assign late_hour_out   = res_reg.stored_hour;
    assign late_minute_out = res_reg.stored_minute;
    assign late_second_out = res_reg.stored_second;

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the time set editor: table-driven directed ticks, then random ticks.
`timescale 1ns / 1ps

module tb;

    localparam int BLINK_TICKS    = 20;
    localparam int RAND_PER_PHASE = 115;
    localparam int HOLD_CYCLES    = 60;
    localparam int TIMEOUT_NS     = 2_000_000;

    // edit_target values, and the table's "leave the register alone" mark
    localparam int TGT_KEEP  = -1;
    localparam int TGT_CLOCK = 0;
    localparam int TGT_LATE  = 1;

    // One poll tick as offered on the input channel
    typedef struct packed {
        logic [7:0] inc;
        logic [7:0] dec;
        logic [7:0] mode;
        logic [4:0] hr;
        logic [5:0] mn;
        logic [5:0] sc;
    } key_tick_t;

    // One row of the directed table
    typedef struct {
        key_tick_t        tk;
        int               tgt;
        bit               typed;
        tse_pkg::result_t want;
    } script_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  inc_hold = '0;
    logic [7:0]  dec_hold = '0;
    logic [7:0]  mode_hold = '0;
    logic [4:0]  rtc_hour = '0;
    logic [5:0]  rtc_minute = '0;
    logic [5:0]  rtc_second = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  phase;
    logic [4:0]  shown_hour;
    logic [5:0]  shown_minute;
    logic [5:0]  shown_second;
    logic [1:0]  blank_field;
    logic        rtc_write;
    logic [4:0]  late_hour_out;
    logic [5:0]  late_minute_out;
    logic [5:0]  late_second_out;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;

    time_set_editor #(
        .BLINK_PERIOD(BLINK_TICKS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .inc_hold       (inc_hold),
        .dec_hold       (dec_hold),
        .mode_hold      (mode_hold),
        .rtc_hour       (rtc_hour),
        .rtc_minute     (rtc_minute),
        .rtc_second     (rtc_second),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .phase          (phase),
        .shown_hour     (shown_hour),
        .shown_minute   (shown_minute),
        .shown_second   (shown_second),
        .blank_field    (blank_field),
        .rtc_write      (rtc_write),
        .late_hour_out  (late_hour_out),
        .late_minute_out(late_minute_out),
        .late_second_out(late_second_out),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    // Mirrored editor state
    logic [2:0] ed_phase = tse_pkg::PH_IDLE;
    int         blink_tick = 0;
    logic [4:0] work_h = '0;
    logic [5:0] work_m = '0;
    logic [5:0] work_s = '0;
    logic [4:0] late_h = '0;
    logic [5:0] late_m = '0;
    logic [5:0] late_s = '0;
    bit         tgt_late = 1'b0;

    // Results still owed by the block, oldest first
    tse_pkg::result_t tick_results[$];

    int          errors = 0;
    int          n_checked = 0;
    int          n_cfg = 0;
    int          n_writes = 0;
    int          n_blanked = 0;
    logic [7:0]  phases_seen = '0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_off_req = 1'b0;

    // Directed ticks: plain rows are checked against the predictor,
    // typed rows carry the result that follows directly from reset values.
    script_row_t script [0:25] = '{
        // idle after reset shows the clock inputs
        '{'{8'd0, 8'd0, 8'd0, 5'd12, 6'd34, 6'd56}, TGT_KEEP, 1'b1,
          '{tse_pkg::PH_IDLE, 5'd12, 6'd34, 6'd56, tse_pkg::BLANK_NONE, 1'b0, 5'd0, 6'd0, 6'd0}},
        '{'{8'd0, 8'd0, 8'd1, 5'd23, 6'd59, 6'd59}, TGT_KEEP, 1'b1,
          '{tse_pkg::PH_IDLE, 5'd23, 6'd59, 6'd59, tse_pkg::BLANK_NONE, 1'b0, 5'd0, 6'd0, 6'd0}},
        // fetch copies the clock time
        '{'{8'd0, 8'd0, 8'd0, 5'd0, 6'd0, 6'd0}, TGT_KEEP, 1'b1,
          '{tse_pkg::PH_FETCH, 5'd0, 6'd0, 6'd0, tse_pkg::BLANK_NONE, 1'b0, 5'd0, 6'd0, 6'd0}},
        // hour wraps down from zero, then up from the top
        '{'{8'd0, 8'd1, 8'd0, 5'd5, 6'd6, 6'd7}, TGT_KEEP, 1'b1,
          '{tse_pkg::PH_HOUR, 5'd0, 6'd0, 6'd0, tse_pkg::BLANK_NONE, 1'b0, 5'd0, 6'd0, 6'd0}},
        '{'{8'd1, 8'd0, 8'd0, 5'd5, 6'd6, 6'd7}, TGT_KEEP, 1'b0, '0},
        // both keys on auto-repeat cancel out
        '{'{8'd25, 8'd255, 8'd0, 5'd5, 6'd6, 6'd7}, TGT_KEEP, 1'b0, '0},
        '{'{8'd20, 8'd0, 8'd1, 5'd5, 6'd6, 6'd7}, TGT_KEEP, 1'b0, '0},
        '{'{8'd0, 8'd1, 8'd0, 5'd5, 6'd6, 6'd7}, TGT_KEEP, 1'b0, '0},
        '{'{8'd21, 8'd0, 8'd2, 5'd5, 6'd6, 6'd7}, TGT_KEEP, 1'b0, '0},
        '{'{8'd0, 8'd0, 8'd1, 5'd5, 6'd6, 6'd7}, TGT_KEEP, 1'b0, '0},
        '{'{8'd1, 8'd0, 8'd255, 5'd5, 6'd6, 6'd7}, TGT_KEEP, 1'b0, '0},
        '{'{8'd0, 8'd0, 8'd1, 5'd5, 6'd6, 6'd7}, TGT_KEEP, 1'b0, '0},
        // write phase reached with the late target: back to idle, no strobe
        '{'{8'd0, 8'd0, 8'd0, 5'd5, 6'd6, 6'd7}, TGT_LATE, 1'b1,
          '{tse_pkg::PH_WRITE, 5'd0, 6'd0, 6'd0, tse_pkg::BLANK_NONE, 1'b0, 5'd0, 6'd0, 6'd0}},
        // out-of-range clock time goes through fetch and the field steps
        '{'{8'd0, 8'd0, 8'd1, 5'd31, 6'd63, 6'd63}, TGT_CLOCK, 1'b1,
          '{tse_pkg::PH_IDLE, 5'd31, 6'd63, 6'd63, tse_pkg::BLANK_NONE, 1'b0, 5'd0, 6'd0, 6'd0}},
        '{'{8'd0, 8'd0, 8'd0, 5'd31, 6'd63, 6'd63}, TGT_KEEP, 1'b0, '0},
        '{'{8'd1, 8'd0, 8'd0, 5'd0, 6'd0, 6'd0}, TGT_KEEP, 1'b0, '0},
        '{'{8'd0, 8'd0, 8'd1, 5'd0, 6'd0, 6'd0}, TGT_KEEP, 1'b0, '0},
        '{'{8'd0, 8'd1, 8'd0, 5'd0, 6'd0, 6'd0}, TGT_KEEP, 1'b0, '0},
        '{'{8'd0, 8'd0, 8'd1, 5'd0, 6'd0, 6'd0}, TGT_KEEP, 1'b0, '0},
        '{'{8'd1, 8'd0, 8'd0, 5'd0, 6'd0, 6'd0}, TGT_KEEP, 1'b0, '0},
        '{'{8'd0, 8'd0, 8'd1, 5'd0, 6'd0, 6'd0}, TGT_KEEP, 1'b0, '0},
        // write strobe carries the edited time
        '{'{8'd0, 8'd0, 8'd0, 5'd7, 6'd8, 6'd9}, TGT_KEEP, 1'b0, '0},
        '{'{8'd0, 8'd0, 8'd1, 5'd16, 6'd32, 6'd48}, TGT_KEEP, 1'b0, '0},
        // fetch phase reached with the late target: back to idle
        '{'{8'd0, 8'd0, 8'd0, 5'd16, 6'd32, 6'd48}, TGT_LATE, 1'b1,
          '{tse_pkg::PH_FETCH, 5'd0, 6'd0, 6'd0, tse_pkg::BLANK_NONE, 1'b0, 5'd0, 6'd0, 6'd0}},
        '{'{8'd0, 8'd0, 8'd1, 5'd16, 6'd32, 6'd48}, TGT_KEEP, 1'b1,
          '{tse_pkg::PH_IDLE, 5'd0, 6'd0, 6'd0, tse_pkg::BLANK_NONE, 1'b0, 5'd0, 6'd0, 6'd0}},
        // late hour wraps down from zero
        '{'{8'd0, 8'd1, 8'd0, 5'd16, 6'd32, 6'd48}, TGT_KEEP, 1'b1,
          '{tse_pkg::PH_HOUR, 5'd0, 6'd0, 6'd0, tse_pkg::BLANK_NONE, 1'b0, 5'd23, 6'd0, 6'd0}}
    };

    // Settings for the random phases
    int phase_tgt [0:5] = '{TGT_CLOCK, TGT_LATE, TGT_LATE, TGT_CLOCK, TGT_LATE, TGT_CLOCK};

    // Key press: first tick of a hold, then every fifth tick past 20
    function automatic bit key_fires(logic [7:0] n);
        return (n == 8'd1) || ((n > 8'd20) && (n % 8'd5 == 8'd0));
    endfunction

    // Step a field up then down, wrapping over 0..modulus-1
    function automatic int wrap_field(int v, int modulus, bit up, bit down);
        int w;
        w = v;
        if (up)
            w = (w + 1) % modulus;
        if (down)
            w = (w == 0 || w > modulus) ? modulus - 1 : w - 1;
        return w;
    endfunction

    // Advance the mirrored editor by one tick and return its result
    function automatic tse_pkg::result_t edit_tick(key_tick_t t);
        tse_pkg::result_t r;
        bit               up;
        bit               down;
        bit               mpress;
        bit               blank_now;
        logic [2:0]       nxt;
        logic [4:0]       h;
        logic [5:0]       m;
        logic [5:0]       s;
        up        = key_fires(t.inc);
        down      = key_fires(t.dec);
        mpress    = (t.mode == 8'd1);
        blank_now = (t.inc == 8'd0) && (t.dec == 8'd0) && (blink_tick < BLINK_TICKS / 2);
        h = tgt_late ? late_h : work_h;
        m = tgt_late ? late_m : work_m;
        s = tgt_late ? late_s : work_s;
        r = '0;
        r.phase        = ed_phase;
        r.shown_hour   = h;
        r.shown_minute = m;
        r.shown_second = s;
        nxt = tse_pkg::PH_IDLE;
        case (ed_phase)
            tse_pkg::PH_IDLE:
            begin
                if (!tgt_late)
                begin
                    r.shown_hour   = t.hr;
                    r.shown_minute = t.mn;
                    r.shown_second = t.sc;
                end
                if (mpress)
                    nxt = tgt_late ? tse_pkg::PH_HOUR : tse_pkg::PH_FETCH;
            end
            tse_pkg::PH_FETCH:
            begin
                if (!tgt_late)
                begin
                    work_h = t.hr;
                    work_m = t.mn;
                    work_s = t.sc;
                    r.shown_hour   = t.hr;
                    r.shown_minute = t.mn;
                    r.shown_second = t.sc;
                    nxt = tse_pkg::PH_HOUR;
                end
            end
            tse_pkg::PH_HOUR:
            begin
                if (blank_now)
                    r.blank_field = tse_pkg::BLANK_HOUR;
                h = 5'(wrap_field(int'(h), 24, up, down));
                if (tgt_late)
                    late_h = h;
                else
                    work_h = h;
                nxt = mpress ? tse_pkg::PH_MINUTE : tse_pkg::PH_HOUR;
            end
            tse_pkg::PH_MINUTE:
            begin
                if (blank_now)
                    r.blank_field = tse_pkg::BLANK_MINUTE;
                m = 6'(wrap_field(int'(m), 60, up, down));
                if (tgt_late)
                    late_m = m;
                else
                    work_m = m;
                nxt = mpress ? tse_pkg::PH_SECOND : tse_pkg::PH_MINUTE;
            end
            tse_pkg::PH_SECOND:
            begin
                if (blank_now)
                    r.blank_field = tse_pkg::BLANK_SECOND;
                s = 6'(wrap_field(int'(s), 60, up, down));
                if (tgt_late)
                    late_s = s;
                else
                    work_s = s;
                if (mpress)
                    nxt = tgt_late ? tse_pkg::PH_IDLE : tse_pkg::PH_WRITE;
                else
                    nxt = tse_pkg::PH_SECOND;
            end
            tse_pkg::PH_WRITE:
                r.rtc_write = !tgt_late;
            default:
                ;
        endcase
        ed_phase   = nxt;
        blink_tick = (blink_tick + 1) % BLINK_TICKS;
        r.stored_hour   = late_h;
        r.stored_minute = late_m;
        r.stored_second = late_s;
        return r;
    endfunction

    // Hold count: mostly released or a fresh press, some auto-repeat, some anything
    function automatic logic [7:0] random_hold();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return 8'd0;
        if (pick < 7)
            return 8'd1;
        if (pick < 8)
            return 8'($urandom_range(60, 21));
        return 8'($urandom_range(255));
    endfunction

    function automatic key_tick_t random_tick();
        key_tick_t   t;
        int unsigned pick;
        t.inc = random_hold();
        t.dec = random_hold();
        pick = $urandom_range(19);
        if (pick < 3)
            t.mode = 8'd1;
        else if (pick < 17)
            t.mode = 8'd0;
        else
            t.mode = 8'($urandom_range(255));
        // now and then an out-of-range clock time
        t.hr = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
        t.mn = ($urandom_range(15) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
        t.sc = ($urandom_range(15) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
        return t;
    endfunction

    task automatic wait_drained();
        while (tick_results.size() != 0)
            @(posedge clk);
    endtask

    // Change the edit target once every owed result is back
    task automatic set_target(int tgt);
        in_valid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= (tgt == TGT_LATE);
        @(posedge clk);
        cfg_we   <= 1'b0;
        tgt_late = (tgt == TGT_LATE);
        n_cfg++;
    endtask

    // Random sender idle cycles before the next item
    task automatic idle_gap();
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offer one tick, wait for it to be taken, then log its expected result
    task automatic offer_tick(key_tick_t t, bit typed, tse_pkg::result_t want);
        tse_pkg::result_t predicted;
        in_valid   <= 1'b1;
        inc_hold   <= t.inc;
        dec_hold   <= t.dec;
        mode_hold  <= t.mode;
        rtc_hour   <= t.hr;
        rtc_minute <= t.mn;
        rtc_second <= t.sc;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = edit_tick(t);
        tick_results.push_back(typed ? want : predicted);
    endtask

    task automatic report_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        tse_pkg::result_t got;
        tse_pkg::result_t want;
        got = {phase, shown_hour, shown_minute, shown_second, blank_field, rtc_write,
               late_hour_out, late_minute_out, late_second_out};
        if (tick_results.size() == 0)
        begin
            errors++;
            $display("%0t ns: result with nothing expected, expected none, got %h", $time, got);
        end
        else
        begin
            want = tick_results.pop_front();
            report_field("phase", want.phase, got.phase);
            report_field("shown_hour", want.shown_hour, got.shown_hour);
            report_field("shown_minute", want.shown_minute, got.shown_minute);
            report_field("shown_second", want.shown_second, got.shown_second);
            report_field("blank_field", want.blank_field, got.blank_field);
            report_field("rtc_write", want.rtc_write, got.rtc_write);
            report_field("late_hour_out", want.stored_hour, got.stored_hour);
            report_field("late_minute_out", want.stored_minute, got.stored_minute);
            report_field("late_second_out", want.stored_second, got.stored_second);
        end
        n_checked++;
        if (got.rtc_write)
            n_writes++;
        if (got.blank_field != tse_pkg::BLANK_NONE)
            n_blanked++;
        phases_seen[got.phase] = 1'b1;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: check accepted items, then pick the next ready level
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_result();
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        send_idle_pct = 28;
        recv_idle_pct = 45;
        foreach (script[i])
        begin
            if (script[i].tgt != TGT_KEEP)
                set_target(script[i].tgt);
            idle_gap();
            offer_tick(script[i].tk, script[i].typed, script[i].want);
        end

        // random phases: receiver-heavy idling, sender-heavy idling, then none
        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 28;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_target(phase_tgt[p]);
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                // long receiver stall while items keep coming
                if (p == 4 && k == 20)
                    hold_off_req = 1'b1;
                // sender pause until the pipeline is empty
                if (p == 5 && k == RAND_PER_PHASE / 2)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                idle_gap();
                offer_tick(random_tick(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);

        $display("Run covered %0d ticks over %0d edit-target writes, both targets.", n_checked,
                 n_cfg);
        $display("Saw %0d clock write-backs, %0d blanked ticks, phase codes seen %b.", n_writes,
                 n_blanked, phases_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still owed", tick_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
